>>> hw/rtl/pfre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfre_pkg: shared types and constants for the page frame raster engine
// Store geometry, command codes and the walker's request/response structs.
// ---------------------------------------------------------------------------
package pfre_pkg;

  // Frame store geometry (fixed)
  localparam int STORE_BYTES   = 1024;
  localparam int ADDR_W        = 10;
  localparam int ROWS_PER_PAGE = 8;
  localparam int BIT_W         = 3;

  // Coordinate widths: full-width ends reach 255 + 255 - 1
  localparam int CRD_W  = 9;
  localparam int PIX_W  = 8;
  localparam int PAGE_W = 5;
  // x + page * width spans up to 255 + 31 * 256
  localparam int FULL_W = 14;

  // Command codes (code 7 is unused)
  typedef enum logic [2:0] {
    MODE_PIXEL = 3'd0,
    MODE_HLINE = 3'd1,
    MODE_VLINE = 3'd2,
    MODE_RECT  = 3'd3,
    MODE_FILL  = 3'd4,
    MODE_CLEAR = 3'd5,
    MODE_READ  = 3'd6
  } mode_e;

  // One filled box to walk, inclusive bounds, not yet clipped
  typedef struct packed {
    logic             empty;
    logic [CRD_W-1:0] x_lo;
    logic [CRD_W-1:0] x_hi;
    logic [CRD_W-1:0] y_lo;
    logic [CRD_W-1:0] y_hi;
  } rect_t;

  // Current frame byte of the walk
  typedef struct packed {
    logic                  active;
    logic                  last;
    logic                  hit;
    logic [ADDR_W-1:0]     addr;
    logic [ROWS_PER_PAGE-1:0] mask;
  } walk_pos_t;

endpackage

`default_nettype wire

>>> hw/rtl/page_framebuffer_raster_engine.sv
// Order of work: a read byte is taken from the frame memory, then given out;
//   clear writes zero to every frame byte; drawing reads and then writes each frame
//   byte touched, box by box (an outline is four boxes). Reversed corners or unused mode touch no byte.
// Flow: one command at a time; the single-port frame memory does each
//   read-modify-write as a read and then a write. A result may wait while the next is taken.
// Reset: a clearing pass zeroes the frame memory; no command is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// page_framebuffer_raster_engine: monochrome page-organized frame buffer
// Draws pixels, lines and boxes into a 1024-byte store of 8-row pages by
// read-modify-write, clears it, and reads single bytes for the display link.
// ---------------------------------------------------------------------------
module page_framebuffer_raster_engine import pfre_pkg::*; #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] x_start, [15:8] y_start, [23:16] x_end, [31:24] y_end,
  // [39:32] line_length, [40] erase_pixel, [50:41] byte_index, [55:51] zero
  input  wire logic [55:0] s_axis_tdata,
  // [2:0] mode
  input  wire logic [2:0]  s_axis_tuser,
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data
  output logic [7:0]       m_axis_tdata,
  // [0] status
  output logic [0:0]       m_axis_tuser
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_RD,
    ST_WR,
    ST_RDATA,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              clr_cmd_q;
  logic [1:0]        job_idx_q, job_last_q;
  logic [7:0]        res_data_q;
  logic              res_status_q;
  logic              m_tvalid_q;
  logic [7:0]        m_data_q;
  logic              m_status_q;

  // Latched command
  mode_e             mode_q;
  logic [PIX_W-1:0]  xs_q, ys_q, xe_q, ye_q, len_q;
  logic              erase_q;

  // Input field views
  logic              in_fire;
  mode_e             in_mode;
  logic [PIX_W-1:0]  in_xs, in_ys, in_xe, in_ye, in_len;
  logic              in_erase, in_rev;
  logic [ADDR_W-1:0] in_idx;

  // Frame memory
  logic [7:0]        mem [STORE_BYTES];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata, rdata_q;

  rect_t             job;
  walk_pos_t         walk;

  assign in_mode  = mode_e'(s_axis_tuser);
  assign in_xs    = s_axis_tdata[7:0];
  assign in_ys    = s_axis_tdata[15:8];
  assign in_xe    = s_axis_tdata[23:16];
  assign in_ye    = s_axis_tdata[31:24];
  assign in_len   = s_axis_tdata[39:32];
  assign in_erase = s_axis_tdata[40];
  assign in_idx   = s_axis_tdata[50:41];
  assign in_rev   = (in_xe < in_xs) || (in_ye < in_ys);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

  // Box for the current job of the command
  always_comb begin
    job      = '0;
    job.x_lo = {1'b0, xs_q};
    job.x_hi = {1'b0, xs_q};
    job.y_lo = {1'b0, ys_q};
    job.y_hi = {1'b0, ys_q};
    unique case (mode_q)
      MODE_PIXEL: ;
      MODE_HLINE: begin
        job.x_hi  = {1'b0, xs_q} + {1'b0, len_q} - CRD_W'(1);
        job.empty = (len_q == '0);
      end
      MODE_VLINE: begin
        job.y_hi  = {1'b0, ys_q} + {1'b0, len_q} - CRD_W'(1);
        job.empty = (len_q == '0);
      end
      MODE_RECT: begin
        unique case (job_idx_q)
          2'd0: begin  // top edge
            job.x_hi = {1'b0, xe_q};
          end
          2'd1: begin  // bottom edge
            job.x_hi = {1'b0, xe_q};
            job.y_lo = {1'b0, ye_q};
            job.y_hi = {1'b0, ye_q};
          end
          2'd2: begin  // left edge
            job.y_hi = {1'b0, ye_q};
          end
          2'd3: begin  // right edge
            job.x_lo = {1'b0, xe_q};
            job.x_hi = {1'b0, xe_q};
            job.y_hi = {1'b0, ye_q};
          end
        endcase
      end
      MODE_FILL: begin
        job.x_hi = {1'b0, xe_q};
        job.y_hi = {1'b0, ye_q};
      end
      default: job.empty = 1'b1;
    endcase
  end

  pfre_walker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (state_q == ST_LOAD),
    .rect_i (job),
    .step_i (state_q == ST_WR),
    .pos_o  (walk)
  );

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = walk.addr;
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_q;
      end
      ST_IDLE: begin
        mem_re   = in_fire && (in_mode == MODE_READ);
        mem_addr = in_idx;
      end
      ST_RD: mem_re = walk.active;
      ST_WR: begin
        mem_we    = walk.hit;
        mem_wdata = erase_q ? (rdata_q & ~walk.mask) : (rdata_q | walk.mask);
      end
      default: ;
    endcase
  end

  // Frame memory, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // Command capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= in_mode;
      xs_q    <= in_xs;
      ys_q    <= in_ys;
      xe_q    <= in_xe;
      ye_q    <= in_ye;
      len_q   <= in_len;
      erase_q <= (in_mode == MODE_PIXEL) && in_erase;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      clr_cmd_q    <= 1'b0;
      job_idx_q    <= '0;
      job_last_q   <= '0;
      res_data_q   <= '0;
      res_status_q <= 1'b0;
      m_tvalid_q   <= 1'b0;
      m_data_q     <= '0;
      m_status_q   <= 1'b0;
    end else begin
      // Result leaves unless a new one replaces it this cycle
      if (m_tvalid_q && m_axis_tready && (state_q != ST_FINISH)) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
          if (clr_cnt_q == ADDR_W'(STORE_BYTES - 1)) begin
            state_q <= clr_cmd_q ? ST_FINISH : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            res_data_q   <= '0;
            res_status_q <= ((in_mode == MODE_RECT) || (in_mode == MODE_FILL)) && in_rev;
            job_idx_q    <= '0;
            job_last_q   <= ((in_mode == MODE_RECT) && !in_rev) ? 2'd3 : 2'd0;
            clr_cmd_q    <= (in_mode == MODE_CLEAR);
            unique case (in_mode)
              MODE_PIXEL, MODE_HLINE, MODE_VLINE: state_q <= ST_LOAD;
              MODE_RECT, MODE_FILL: state_q <= in_rev ? ST_FINISH : ST_LOAD;
              MODE_CLEAR: begin
                clr_cnt_q <= '0;
                state_q   <= ST_CLEAR;
              end
              MODE_READ: state_q <= ST_RDATA;
              default:   state_q <= ST_FINISH;
            endcase
          end
        end
        ST_LOAD: state_q <= ST_RD;
        ST_RD: begin
          if (walk.active) begin
            state_q <= ST_WR;
          end else if (job_idx_q == job_last_q) begin
            state_q <= ST_FINISH;
          end else begin
            job_idx_q <= job_idx_q + 2'd1;
            state_q   <= ST_LOAD;
          end
        end
        ST_WR: state_q <= ST_RD;
        ST_RDATA: begin
          res_data_q <= rdata_q;
          state_q    <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid_q || m_axis_tready) begin
            m_tvalid_q <= 1'b1;
            m_data_q   <= res_data_q;
            m_status_q <= res_status_q;
            state_q    <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Checks
  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_mode == MODE_READ) |=> state_q == ST_RDATA)
    else $error("read command did not go to read data state");

  a_clear_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_mode == MODE_CLEAR) |=> (state_q == ST_CLEAR) && (clr_cnt_q == '0))
    else $error("clear pass did not start at byte zero");

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("frame memory read and write in the same cycle");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && (!m_tvalid_q || m_axis_tready)
      |=> m_axis_tvalid && (state_q == ST_IDLE))
    else $error("finished command gave no result");

endmodule

`default_nettype wire

>>> hw/rtl/pfre_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfre_walker: byte walker over a clipped box
// Clips a box to the screen and steps through its frame bytes column by
// column, page by page, giving the byte address and the row mask in it.
// ---------------------------------------------------------------------------
module pfre_walker import pfre_pkg::*; #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,   // take a new box
  input  wire rect_t     rect_i,
  input  wire logic      step_i,   // current byte done
  output walk_pos_t      pos_o
);

  localparam logic [CRD_W-1:0]  X_LAST  = CRD_W'(SCREEN_WIDTH - 1);
  localparam logic [CRD_W-1:0]  Y_LAST  = CRD_W'(SCREEN_HEIGHT - 1);
  localparam logic [FULL_W-1:0] WIDTH_C = FULL_W'(SCREEN_WIDTH);
  localparam logic [FULL_W-1:0] STORE_C = FULL_W'(STORE_BYTES);

  logic              active_q;
  logic [PIX_W-1:0]  x_q, x_lo_q, x_hi_q;
  logic [PIX_W-1:0]  y_lo_q, y_hi_q;
  logic [PAGE_W-1:0] page_q, page_hi_q;

  logic [CRD_W-1:0]  x_hi_clip, y_hi_clip;
  logic              box_empty;
  logic [FULL_W-1:0] addr_full;
  logic              at_x_end, at_last;
  logic [PIX_W-1:0]  row;
  logic [ROWS_PER_PAGE-1:0] mask;

  // Clip the far corner to the screen; empty if the near corner is past it
  assign x_hi_clip = (rect_i.x_hi > X_LAST) ? X_LAST : rect_i.x_hi;
  assign y_hi_clip = (rect_i.y_hi > Y_LAST) ? Y_LAST : rect_i.y_hi;
  assign box_empty = rect_i.empty || (rect_i.x_lo > x_hi_clip) || (rect_i.y_lo > y_hi_clip);

  // Byte address of the current column and page
  assign addr_full = FULL_W'(x_q) + FULL_W'(page_q) * WIDTH_C;

  // Rows of this page that lie inside the box
  always_comb begin
    mask = '0;
    row  = '0;
    for (int b = 0; b < ROWS_PER_PAGE; b++) begin
      row     = {page_q, BIT_W'(b)};
      mask[b] = (row >= y_lo_q) && (row <= y_hi_q);
    end
  end

  assign at_x_end = (x_q == x_hi_q);
  assign at_last  = at_x_end && (page_q == page_hi_q);

  assign pos_o.active = active_q;
  assign pos_o.last   = at_last;
  assign pos_o.hit    = addr_full < STORE_C;
  assign pos_o.addr   = addr_full[ADDR_W-1:0];
  assign pos_o.mask   = mask;

  // Walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (load_i) begin
      active_q <= !box_empty;
    end else if (step_i && at_last) begin
      active_q <= 1'b0;
    end
  end

  // Walk position and bounds
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q       <= rect_i.x_lo[PIX_W-1:0];
      x_lo_q    <= rect_i.x_lo[PIX_W-1:0];
      x_hi_q    <= x_hi_clip[PIX_W-1:0];
      y_lo_q    <= rect_i.y_lo[PIX_W-1:0];
      y_hi_q    <= y_hi_clip[PIX_W-1:0];
      page_q    <= rect_i.y_lo[PIX_W-1:BIT_W];
      page_hi_q <= y_hi_clip[PIX_W-1:BIT_W];
    end else if (step_i && !at_last) begin
      if (at_x_end) begin
        x_q    <= x_lo_q;
        page_q <= page_q + PAGE_W'(1);
      end else begin
        x_q <= x_q + PIX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
